@@ hdl/rmm_pkg.sv @@
// Shared types and constants for the running median multiset block.
package rmm_pkg;

   localparam int CAPACITY    = 64;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int DATA_WIDTH  = 32;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CHANGE = 2'd2,
      OP_CLEAR  = 2'd3
   } rmm_opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } rmm_status_type;

   typedef struct packed {
      logic           accept;
      logic           insert;
      logic           delete_one;
      logic           clear;
      logic           use_new;
      logic           select;
      logic           finish;
      rmm_status_type status;
   } rmm_cmd_type;

   typedef struct packed {
      logic found;
      logic full;
   } rmm_flags_type;

endpackage

@@ hdl/rmm_datapath.sv @@
// Sorted cell chain, median taps and result registers of the running median block.
module rmm_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  rmm_pkg::rmm_cmd_type               cmd,
   input  logic signed [31:0]                 req_value,
   input  logic signed [31:0]                 req_new_value,
   output rmm_pkg::rmm_flags_type             flags,
   output logic signed [31:0]                 rsp_median,
   output logic                               rsp_median_valid,
   output logic [6:0]                         rsp_stored_count,
   output logic [1:0]                         rsp_status
);
   import rmm_pkg::*;

   logic signed [DATA_WIDTH-1:0] cell_ff [CAPACITY];
   logic signed [DATA_WIDTH-1:0] cell_in [CAPACITY];
   logic signed [DATA_WIDTH-1:0] below_cell [CAPACITY];
   logic signed [DATA_WIDTH-1:0] above_cell [CAPACITY];
   logic [COUNT_WIDTH-1:0]       count_ff, count_in;
   logic signed [DATA_WIDTH-1:0] new_value_ff;
   rmm_status_type               status_ff;
   logic signed [DATA_WIDTH-1:0] hi_ff, lo_ff;
   logic                         odd_ff, empty_ff;

   logic [CAPACITY-1:0]          valid, eq, ge, gt, at_end, shift_in;
   logic signed [DATA_WIDTH-1:0] ins_value;
   logic [COUNT_WIDTH-1:0]       half;
   logic [DATA_WIDTH-1:0]        hi_tap, lo_tap;
   logic [DATA_WIDTH:0]          diff;
   logic [DATA_WIDTH-1:0]        mid;

   assign ins_value = cmd.use_new ? new_value_ff : req_value;

   // Neighbor taps: each cell sees only the cells directly below and above it.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_nbr
      if (g == 0) begin : g_first
         assign below_cell[g] = cell_ff[g];
      end else begin : g_inner_lo
         assign below_cell[g] = cell_ff[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign above_cell[g] = cell_ff[g];
      end else begin : g_inner_hi
         assign above_cell[g] = cell_ff[g+1];
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid[i]  = COUNT_WIDTH'(i) < count_ff;
         at_end[i] = COUNT_WIDTH'(i) == count_ff;
         eq[i]     = valid[i] && (cell_ff[i] == req_value);
         ge[i]     = valid[i] && (cell_ff[i] >= req_value);
         gt[i]     = valid[i] && (cell_ff[i] > ins_value);
      end
   end

   assign shift_in    = {gt[CAPACITY-2:0], 1'b0};
   assign flags.found = |eq;
   assign flags.full  = count_ff == COUNT_WIDTH'(CAPACITY);

   // Insert shifts every cell above the insertion point up by one; delete shifts
   // every cell from the first matching copy down by one. The chain stays sorted,
   // so the first cell not below the value is the first matching copy.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_in[i] = cell_ff[i];
         if (cmd.insert) begin
            if (valid[i] || at_end[i]) begin
               if (shift_in[i]) begin
                  cell_in[i] = below_cell[i];
               end else if (gt[i] || at_end[i]) begin
                  cell_in[i] = ins_value;
               end
            end
         end else if (cmd.delete_one) begin
            if (ge[i]) begin
               cell_in[i] = above_cell[i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.insert) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (cmd.delete_one) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   // The two middle cells are picked with one-hot gating and an OR tree.
   assign half = count_ff >> 1;
   always_comb begin
      hi_tap = '0;
      lo_tap = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hi_tap = hi_tap | (cell_ff[i] & {DATA_WIDTH{COUNT_WIDTH'(i) == half}});
         lo_tap = lo_tap | (cell_ff[i] & {DATA_WIDTH{COUNT_WIDTH'(i + 1) == half}});
      end
   end

   assign diff = {hi_ff[DATA_WIDTH-1], hi_ff} - {lo_ff[DATA_WIDTH-1], lo_ff};
   assign mid  = lo_ff + diff[DATA_WIDTH:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      if (cmd.accept) begin
         new_value_ff <= req_new_value;
         status_ff    <= cmd.status;
      end
      if (cmd.select) begin
         hi_ff    <= hi_tap;
         lo_ff    <= lo_tap;
         odd_ff   <= count_ff[0];
         empty_ff <= count_ff == '0;
      end
      if (cmd.finish) begin
         if (empty_ff) begin
            rsp_median <= '0;
         end else if (odd_ff) begin
            rsp_median <= hi_ff;
         end else begin
            rsp_median <= mid;
         end
         rsp_median_valid <= !empty_ff;
         rsp_stored_count <= 7'(count_ff);
         rsp_status       <= status_ff;
      end
   end

endmodule

@@ hdl/rmm_ctrl.sv @@
// Sequencing state machine and handshake control of the running median block.
module rmm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_opcode,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rmm_pkg::rmm_flags_type flags,
   output rmm_pkg::rmm_cmd_type   cmd
);
   import rmm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_INSERT = 4'b0010,
      S_SELECT = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.status   = STATUS_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_SELECT;
               case (rmm_opcode_type'(req_opcode))
                  OP_ADD: begin
                     if (flags.full) begin
                        cmd.status = STATUS_FULL;
                     end else begin
                        cmd.insert = 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (flags.found) begin
                        cmd.delete_one = 1'b1;
                     end else begin
                        cmd.status = STATUS_NOT_FOUND;
                     end
                  end
                  OP_CHANGE: begin
                     if (flags.found) begin
                        cmd.delete_one = 1'b1;
                        state_in       = S_INSERT;
                     end else begin
                        cmd.status = STATUS_NOT_FOUND;
                     end
                  end
                  default: begin
                     cmd.clear = 1'b1;
                  end
               endcase
            end
         end
         S_INSERT: begin
            cmd.insert  = 1'b1;
            cmd.use_new = 1'b1;
            state_in    = S_SELECT;
         end
         S_SELECT: begin
            cmd.select = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/running_median_multiset.sv @@
// Top level of the running median block over a bounded sorted multiset.
//
// Usage: each request beat carries an opcode (add, remove, change, clear), a
// value and a replacement value. Every request beat produces exactly one
// response beat with the median after the operation, a median valid flag,
// the number of held values and a status code (ok, not found, full).
// Both channels use valid/ready; a beat moves when both are high.
//
// Sequencing: for add, remove and clear the accepting edge updates the chain,
// the select step taps the two middle cells into registers, and the finish
// step forms the midpoint into the output register. A change removes at the
// accepting edge and inserts in a step of its own before the select step,
// because its remove and its insert each use the cell chain. A new request is
// taken once the previous one has moved its response into the output
// register, so no request is taken while the previous one is still in work.
//
// Reset clears the count and the control state; the cells hold no valid
// data until written and need no clearing. When the receiver stalls, the
// response register holds its beat, and a following request is taken and
// worked on, but waits in its last step until the output register is free.
module running_median_multiset (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_new_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_median,
   output logic               rsp_median_valid,
   output logic [6:0]         rsp_stored_count,
   output logic [1:0]         rsp_status
);
   import rmm_pkg::*;

   rmm_cmd_type   cmd;
   rmm_flags_type flags;

   // The controller decides each step from the opcode and the chain's
   // found and full flags; the datapath only follows its commands.
   rmm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .flags      (flags),
      .cmd        (cmd)
   );

   rmm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_value        (req_value),
      .req_new_value    (req_new_value),
      .flags            (flags),
      .rsp_median       (rsp_median),
      .rsp_median_valid (rsp_median_valid),
      .rsp_stored_count (rsp_stored_count),
      .rsp_status       (rsp_status)
   );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the running median multiset, with directed and random beats.
module testbench;
   import rmm_pkg::*;

   localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POSITIVE = 32'sh7FFF_FFFF;
   localparam int RANDOM_ITEMS = 360;
   // The last beats of the run go out with no idling on either channel.
   localparam int QUIET_TAIL = 40;

   // Shapes of the random stimulus. Grow and shrink phases mostly act on values
   // that are really held, so the store sweeps through its whole depth; noise
   // phases throw in clears and values that are likely missing.
   typedef enum {PHASE_FILL, PHASE_GROW, PHASE_SHRINK, PHASE_NOISE} phase_kind_type;

   typedef struct {
      logic signed [31:0] median;
      logic               median_valid;
      logic [6:0]         count;
      rmm_status_type     status;
   } median_result_type;

   // Tracks the multiset as a sorted queue and keeps the responses that are
   // still owed, oldest first.
   class median_scoreboard;
      logic signed [31:0] held[$];
      median_result_type  awaited[$];
      int                 failures = 0;

      function int find_value(logic signed [31:0] v);
         foreach (held[i]) begin
            if (held[i] == v) return i;
         end
         return -1;
      endfunction

      // A new value goes in after every copy of an equal value.
      function void insert_value(logic signed [31:0] v);
         int p;
         p = 0;
         while (p < held.size() && held[p] <= v) p++;
         held.insert(p, v);
      endfunction

      function void note_request(rmm_opcode_type op, logic signed [31:0] value,
                                 logic signed [31:0] new_value);
         median_result_type result;
         rmm_status_type    status;
         int                pos;
         longint            lower;
         longint            upper;
         status = STATUS_OK;
         case (op)
            OP_ADD: begin
               if (held.size() >= CAPACITY) status = STATUS_FULL;
               else insert_value(value);
            end
            OP_REMOVE: begin
               pos = find_value(value);
               if (pos < 0) status = STATUS_NOT_FOUND;
               else held.delete(pos);
            end
            OP_CHANGE: begin
               pos = find_value(value);
               if (pos < 0) begin
                  status = STATUS_NOT_FOUND;
               end else begin
                  held.delete(pos);
                  insert_value(new_value);
               end
            end
            default: held.delete();
         endcase
         result.status       = status;
         result.count        = 7'(held.size());
         result.median_valid = held.size() != 0;
         if (held.size() == 0) begin
            result.median = '0;
         end else if (held.size() % 2 == 1) begin
            result.median = held[held.size() / 2];
         end else begin
            // The difference of the two middle values is taken 64 bits wide and
            // is never negative, so halving it rounds the midpoint down.
            lower = held[held.size() / 2 - 1];
            upper = held[held.size() / 2];
            result.median = 32'(lower + ((upper - lower) >> 1));
         end
         awaited.insert(awaited.size(), result);
      endfunction

      function void check_response(logic signed [31:0] median, logic median_valid,
                                   logic [6:0] count, logic [1:0] status);
         median_result_type want;
         if (awaited.size() == 0) begin
            $error("response beat with no request outstanding");
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (median !== want.median) begin
            $error("median: expected %0d, got %0d", want.median, median);
            failures++;
         end
         if (median_valid !== want.median_valid) begin
            $error("median_valid: expected %0d, got %0d", want.median_valid, median_valid);
            failures++;
         end
         if (count !== want.count) begin
            $error("stored_count: expected %0d, got %0d", want.count, count);
            failures++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            failures++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_opcode = OP_CLEAR;
   logic signed [31:0] req_value = '0;
   logic signed [31:0] req_new_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_median;
   logic               rsp_median_valid;
   logic [6:0]         rsp_stored_count;
   logic [1:0]         rsp_status;

   median_scoreboard board;
   int               sent_count = 0;
   int               quiet_from = 32'h7FFF_FFFF;
   logic             quiet = 1'b0;

   running_median_multiset dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_value        (req_value),
      .req_new_value    (req_new_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_median       (rsp_median),
      .rsp_median_valid (rsp_median_valid),
      .rsp_stored_count (rsp_stored_count),
      .rsp_status       (rsp_status)
   );

   always #6 clock = ~clock;

   // The run is cut off well beyond the slowest correct run, which is a few
   // hundred beats that each wait out a full sender gap and receiver stall.
   initial begin
      #(12 * 150000);
      $display("tb: failure");
      $finish;
   end

   // Values come from the full range, from a narrow band around zero so that
   // duplicates are common, from the extremes, and from what is already held.
   function automatic logic signed [31:0] pick_value();
      int                 roll;
      logic signed [31:0] v;
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
         v = $urandom();
      end else if (roll < 7) begin
         v = $signed($urandom_range(0, 12)) - 6;
      end else if (roll < 8) begin
         case ($urandom_range(0, 3))
            0:       v = MOST_NEGATIVE;
            1:       v = MOST_POSITIVE;
            2:       v = -1;
            default: v = 0;
         endcase
      end else if (board.held.size() != 0) begin
         v = board.held[$urandom_range(0, board.held.size() - 1)];
      end else begin
         v = $urandom();
      end
      return v;
   endfunction

   // Sends one request beat, sometimes after a burst of idle cycles, and hands
   // it to the scoreboard at the edge where it is accepted.
   task automatic send_request(rmm_opcode_type op, logic signed [31:0] value,
                               logic signed [31:0] new_value);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_value     <= value;
      req_new_value <= new_value;
      do @(posedge clock); while (!req_ready);
      board.note_request(op, value, new_value);
      sent_count++;
      if (sent_count >= quiet_from) quiet <= 1'b1;
   endtask

   // One random beat; the percentages pick the operation and the rest are
   // clears. A well-formed beat removes or changes a value that is held, most
   // of the time.
   task automatic issue_mixed(int add_pct, int remove_pct, int change_pct, bit well_formed);
      int                 roll;
      logic signed [31:0] value;
      roll  = $urandom_range(0, 99);
      value = pick_value();
      if (well_formed && board.held.size() != 0 && $urandom_range(0, 9) != 0)
         value = board.held[$urandom_range(0, board.held.size() - 1)];
      if (roll < add_pct)
         send_request(OP_ADD, pick_value(), $urandom());
      else if (roll < add_pct + remove_pct)
         send_request(OP_REMOVE, value, $urandom());
      else if (roll < add_pct + remove_pct + change_pct)
         send_request(OP_CHANGE, value, pick_value());
      else
         send_request(OP_CLEAR, value, $urandom());
   endtask

   // Every response beat that moves is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_median, rsp_median_valid, rsp_stored_count, rsp_status);
   end

   // The receiver alternates between ready stretches and stall bursts, both of
   // random length, and stops stalling in the quiet tail.
   initial begin
      @(posedge clock);
      forever begin
         if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   initial begin
      int             target;
      int             span;
      bit             filled;
      phase_kind_type kind;
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Operations on an empty set: nothing to remove or change, and a clear
      // that changes nothing. The median reads as zero and is marked invalid.
      send_request(OP_REMOVE, 5, 0);
      send_request(OP_CHANGE, 5, 6);
      send_request(OP_CLEAR, 0, 0);
      // The two extremes together: the midpoint needs a wide difference.
      send_request(OP_ADD, MOST_NEGATIVE, 0);
      send_request(OP_ADD, MOST_POSITIVE, 0);
      send_request(OP_ADD, MOST_POSITIVE, 0);
      send_request(OP_REMOVE, MOST_NEGATIVE, 0);
      send_request(OP_ADD, 0, 0);
      send_request(OP_ADD, 0, MOST_NEGATIVE);
      // Changes that move a copy across the middle and to the bottom.
      send_request(OP_CHANGE, 0, -1);
      send_request(OP_CHANGE, MOST_POSITIVE, MOST_NEGATIVE);
      // Values that are missing from a non-empty set.
      send_request(OP_REMOVE, 7, 0);
      send_request(OP_CHANGE, 12345, 1);
      // A change to the same value, then duplicates added and removed.
      send_request(OP_CHANGE, -1, -1);
      send_request(OP_ADD, -1, 0);
      send_request(OP_REMOVE, -1, 0);
      send_request(OP_CLEAR, 0, 0);
      // An odd midpoint below zero rounds toward minus infinity.
      send_request(OP_ADD, -3, 0);
      send_request(OP_ADD, 0, 0);
      send_request(OP_ADD, 32'sh5555_5555, 32'shAAAA_AAAA);
      send_request(OP_ADD, 32'shAAAA_AAAA, 32'sh5555_5555);
      send_request(OP_CHANGE, 32'sh5555_5555, 32'shAAAA_AAAA);
      send_request(OP_CLEAR, 32'shFFFF_FFFF, 32'shFFFF_FFFF);

      target     = sent_count + RANDOM_ITEMS;
      quiet_from = target - QUIET_TAIL;
      filled     = 1'b0;
      while (sent_count < target) begin
         kind = phase_kind_type'($urandom_range(0, 3));
         // The store is filled at least once, early enough to stay off the tail.
         if (!filled && target - sent_count < 250) kind = PHASE_FILL;
         case (kind)
            PHASE_FILL: begin
               // Fill to capacity, knock on the full store, then change values
               // while it is full, which must not be refused.
               filled = 1'b1;
               while (board.held.size() < CAPACITY)
                  send_request(OP_ADD, pick_value(), $urandom());
               repeat (3) send_request(OP_ADD, pick_value(), $urandom());
               repeat (3) issue_mixed(0, 0, 100, 1'b1);
            end
            PHASE_GROW: begin
               span = $urandom_range(15, 40);
               repeat (span) issue_mixed(62, 15, 22, 1'b1);
            end
            PHASE_SHRINK: begin
               span = $urandom_range(15, 40);
               repeat (span) issue_mixed(20, 45, 34, 1'b1);
            end
            default: begin
               span = $urandom_range(5, 15);
               repeat (span) issue_mixed(25, 25, 25, 1'b0);
            end
         endcase
      end
      req_valid <= 1'b0;

      // Drain what is owed, then keep clocking with no request so that the block
      // can show any response beat that was never asked for.
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
